### sv/eiac_pkg.sv
`default_nettype none
package eiac_pkg;

	localparam int MAX_FRAME_BYTES = 2048;
	localparam int POS_W = $clog2(MAX_FRAME_BYTES);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES - 1);

	localparam logic [7:0]  VHL_EXPECTED = 8'((4 << 4) | (20 >> 2));
	localparam logic [15:0] WORD_MASK    = 16'hffff;
	localparam logic [15:0] ETH_IPV4     = 16'h0800;
	localparam logic [15:0] ETH_ARP      = 16'h0806;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [31:0] LOCAL_IP_RESET = 32'd167772674;

	localparam logic [2:0] REG_LOCAL_IP = 3'd0;

	typedef enum logic [3:0] {
		V_UDP          = 4'd0,
		V_TCP          = 4'd1,
		V_ARP_REQ      = 4'd2,
		V_TRUNC        = 4'd3,
		V_BAD_VHL      = 4'd4,
		V_BAD_CKSUM    = 4'd5,
		V_NOT_OURS     = 4'd6,
		V_FRAGMENT     = 4'd7,
		V_UNK_PROTO    = 4'd8,
		V_UDP_LEN      = 4'd9,
		V_ARP_FMT      = 4'd10,
		V_ARP_NOT_REQ  = 4'd11,
		V_ARP_NOT_OURS = 4'd12,
		V_UNK_ETYPE    = 4'd13
	} verdict_t;

	typedef struct packed {
		logic vhl_bad;
		logic frag;
		logic dst_miss;
		logic arp_fmt;
		logic arp_op;
		logic arp_tip;
		logic syn;
		logic ack;
	} flags_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic [31:0] remote_ip;
		logic [47:0] remote_mac;
		logic [15:0] local_port;
		logic [15:0] remote_port;
		logic        syn_ack_seen;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
		logic [15:0] ip_payload_length;
	} result_t;

	function automatic logic [7:0] arp_fmt_byte(input logic [2:0] k);
		case (k)
			3'd0: arp_fmt_byte = 8'h00;
			3'd1: arp_fmt_byte = 8'h01;
			3'd2: arp_fmt_byte = 8'h08;
			3'd3: arp_fmt_byte = 8'h00;
			3'd4: arp_fmt_byte = 8'h06;
			3'd5: arp_fmt_byte = 8'h04;
			default: arp_fmt_byte = 8'h00;
		endcase
	endfunction

endpackage
`default_nettype wire

### sv/eiac_ifs.sv
`default_nettype none
interface eiac_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eiac_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  verdict;
	logic [31:0] remote_ip;
	logic [47:0] remote_mac;
	logic [15:0] local_port;
	logic [15:0] remote_port;
	logic        syn_ack_seen;
	logic [31:0] seq_number;
	logic [31:0] ack_number;
	logic [15:0] ip_payload_length;
	modport source (output valid, output verdict, output remote_ip, output remote_mac,
		output local_port, output remote_port, output syn_ack_seen, output seq_number,
		output ack_number, output ip_payload_length, input ready);
	modport sink (input valid, input verdict, input remote_ip, input remote_mac,
		input local_port, input remote_port, input syn_ack_seen, input seq_number,
		input ack_number, input ip_payload_length, output ready);
endinterface
`default_nettype wire

### sv/eiac_parse.sv
`default_nettype none
module eiac_parse import eiac_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    b,
	input  wire logic          last,
	input  wire logic [31:0]   host_addr,
	output logic               res_valid,
	output result_t            res
);

	logic [POS_W-1:0] pos_q;
	logic [15:0] etype_q, iplen_q, udplen_q;
	logic [16:0] csum_q;
	logic [7:0]  proto_q;
	logic [31:0] rip_q, ports_q;
	logic [47:0] rmac_q;
	logic [63:0] seqack_q;
	flags_t      flags_q;

	logic [15:0] etype_c, iplen_c, udplen_c, etype_n, iplen_n, udplen_n;
	logic [16:0] csum_c, csum_n;
	logic [17:0] csum_s;
	logic [7:0]  proto_c, proto_n, lbyte;
	logic [31:0] rip_c, ports_c, rip_n, ports_n;
	logic [47:0] rmac_c, rmac_n;
	logic [63:0] seqack_c, seqack_n;
	flags_t      flags_c, flags_n;
	logic [POS_W-1:0] n;
	logic [3:0]  v;
	logic [15:0] plen;
	logic [1:0]  lk;
	int          p;

	assign p = int'(pos_q);
	assign lk = pos_q[1:0] + 2'd2;
	assign lbyte = 8'(host_addr >> {~lk, 3'b000});

	always_comb begin
		// first byte of a frame starts from cleared state
		if (pos_q == '0) begin
			etype_c = '0; iplen_c = '0; udplen_c = '0; csum_c = '0; proto_c = '0;
			rip_c = '0; ports_c = '0; rmac_c = '0; seqack_c = '0; flags_c = '0;
		end else begin
			etype_c = etype_q; iplen_c = iplen_q; udplen_c = udplen_q; csum_c = csum_q;
			proto_c = proto_q; rip_c = rip_q; ports_c = ports_q; rmac_c = rmac_q;
			seqack_c = seqack_q; flags_c = flags_q;
		end
		etype_n = etype_c; iplen_n = iplen_c; udplen_n = udplen_c; csum_n = csum_c;
		proto_n = proto_c; rip_n = rip_c; ports_n = ports_c; rmac_n = rmac_c;
		seqack_n = seqack_c; flags_n = flags_c;
		csum_s = {1'b0, csum_c} + (pos_q[0] ? {10'd0, b} : {2'd0, b, 8'd0});
		if (p == 12 || p == 13) begin
			etype_n = {etype_c[7:0], b};
		end else if (etype_c == ETH_IPV4) begin
			if (p >= 14 && p <= 33)
				csum_n = {1'b0, csum_s[15:0]} + {15'd0, csum_s[17:16]};
			if (p == 14 && b != VHL_EXPECTED)
				flags_n.vhl_bad = 1'b1;
			if (p == 16 || p == 17)
				iplen_n = {iplen_c[7:0], b};
			if ((p == 20 || p == 21) && b != 8'd0)
				flags_n.frag = 1'b1;
			if (p == 23)
				proto_n = b;
			if (p >= 26 && p <= 29)
				rip_n = {rip_c[23:0], b};
			if (p >= 30 && p <= 33 && b != lbyte)
				flags_n.dst_miss = 1'b1;
			if (p >= 34 && p <= 37)
				ports_n = {ports_c[23:0], b};
			if (p == 38 || p == 39)
				udplen_n = {udplen_c[7:0], b};
			if (p >= 38 && p <= 45)
				seqack_n = {seqack_c[55:0], b};
			if (p == 47) begin
				if (b[1]) flags_n.syn = 1'b1;
				if (b[4]) flags_n.ack = 1'b1;
			end
		end else if (etype_c == ETH_ARP) begin
			if (p >= 14 && p <= 19 && b != arp_fmt_byte(3'(p - 14)))
				flags_n.arp_fmt = 1'b1;
			if ((p == 20 && b != 8'd0) || (p == 21 && b != 8'd1))
				flags_n.arp_op = 1'b1;
			if (p >= 22 && p <= 27)
				rmac_n = {rmac_c[39:0], b};
			if (p >= 28 && p <= 31)
				rip_n = {rip_c[23:0], b};
			if (p >= 38 && p <= 41 && b != lbyte)
				flags_n.arp_tip = 1'b1;
		end
	end

	assign n = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;
	assign plen = iplen_n - 16'd20;

	always_comb begin
		if (int'(n) < 14) begin
			v = V_TRUNC;
		end else if (etype_n == ETH_IPV4) begin
			if (int'(n) < 34) v = V_TRUNC;
			else if (flags_n.vhl_bad) v = V_BAD_VHL;
			else if (csum_n != {1'b0, WORD_MASK}) v = V_BAD_CKSUM;
			else if (flags_n.dst_miss) v = V_NOT_OURS;
			else if (flags_n.frag) v = V_FRAGMENT;
			else if (proto_n == PROTO_UDP) begin
				if (int'(n) < 42) v = V_TRUNC;
				else if (udplen_n != plen) v = V_UDP_LEN;
				else v = V_UDP;
			end else if (proto_n == PROTO_TCP) begin
				v = (int'(n) < 54) ? V_TRUNC : V_TCP;
			end else v = V_UNK_PROTO;
		end else if (etype_n == ETH_ARP) begin
			if (int'(n) < 42) v = V_TRUNC;
			else if (flags_n.arp_fmt) v = V_ARP_FMT;
			else if (flags_n.arp_op) v = V_ARP_NOT_REQ;
			else if (flags_n.arp_tip) v = V_ARP_NOT_OURS;
			else v = V_ARP_REQ;
		end else begin
			v = V_UNK_ETYPE;
		end
	end

	always_comb begin
		res = '0;
		res.verdict = v;
		if (v == V_UDP || v == V_TCP) begin
			res.remote_ip = rip_n;
			res.local_port = ports_n[15:0];
			res.remote_port = ports_n[31:16];
			res.ip_payload_length = plen;
			if (v == V_TCP) begin
				res.syn_ack_seen = flags_n.syn & flags_n.ack;
				res.seq_number = seqack_n[63:32];
				res.ack_number = seqack_n[31:0];
			end
		end else if (v == V_ARP_REQ) begin
			res.remote_ip = rip_n;
			res.remote_mac = rmac_n;
		end
	end

	assign res_valid = take & last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= last ? '0 : n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			etype_q <= etype_n; iplen_q <= iplen_n; udplen_q <= udplen_n;
			csum_q <= csum_n; proto_q <= proto_n; rip_q <= rip_n; ports_q <= ports_n;
			rmac_q <= rmac_n; seqack_q <= seqack_n; flags_q <= flags_n;
		end
	end

endmodule
`default_nettype wire

### sv/eth_ip_arp_rx_classifier_unit.sv
// channel   dir  handshake    payload
// in_ch     in   valid/ready  data_byte, last_byte
// out_ch    out  valid/ready  verdict and captured header fields
// apb       in   psel/penable host address register at byte address 0
//
// one byte per cycle while the skid entry is empty; the last byte's verdict is
// set by the single parse pass between the frame state and the result register
// reset clears byte count and result valid flags
// a two-entry result buffer lets input run on while one verdict is stalled
`default_nettype none
module eth_ip_arp_rx_classifier_unit import eiac_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	eiac_in_if.sink          in_ch,
	eiac_out_if.source       out_ch
);

	logic [31:0] host_addr_q;
	logic        take, res_valid;
	result_t     res, out_q, skid_q;
	logic        ov_q, sv_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LOCAL_IP[2]) ? host_addr_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_addr_q <= LOCAL_IP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_LOCAL_IP[2]) begin
			host_addr_q <= pwdata;
		end
	end

	assign in_ch.ready = !sv_q;
	assign take = in_ch.valid & in_ch.ready;

	eiac_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.b         (in_ch.data_byte),
		.last      (in_ch.last_byte),
		.host_addr (host_addr_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (ov_q && !out_ch.ready) begin
			if (res_valid) sv_q <= 1'b1;
		end else if (sv_q) begin
			sv_q <= 1'b0;
		end else begin
			ov_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ov_q && !out_ch.ready) begin
			if (res_valid) skid_q <= res;
		end else if (sv_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.verdict = out_q.verdict;
	assign out_ch.remote_ip = out_q.remote_ip;
	assign out_ch.remote_mac = out_q.remote_mac;
	assign out_ch.local_port = out_q.local_port;
	assign out_ch.remote_port = out_q.remote_port;
	assign out_ch.syn_ack_seen = out_q.syn_ack_seen;
	assign out_ch.seq_number = out_q.seq_number;
	assign out_ch.ack_number = out_q.ack_number;
	assign out_ch.ip_payload_length = out_q.ip_payload_length;

endmodule
`default_nettype wire

### sv/eiac_checker.sv
`default_nettype none
module eiac_checker import eiac_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] verdict
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= V_UNK_ETYPE)
		else $error("verdict code out of range");

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("skid entry not drained");

endmodule

bind eth_ip_arp_rx_classifier_unit eiac_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.verdict   (out_ch.verdict)
);
`default_nettype wire

### dv/eth_ip_arp_rx_classifier_unit_checker.sv
`timescale 1ns / 100ps
module eth_ip_arp_rx_classifier_unit_checker import eiac_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	eiac_in_if               in_ch,
	eiac_out_if              out_ch,
	output int               fail_count,
	output int               verdicts_pending
);

	logic [31:0] host_ip;
	logic [11:0] pos;
	logic [15:0] etype;
	logic [16:0] csum;
	logic [7:0]  proto;
	logic [15:0] ip_len;
	logic [31:0] src_ip;
	logic [47:0] sender_mac;
	logic [31:0] ports;
	logic [63:0] seq_ack;
	logic [15:0] udp_len;
	flags_t      flg;
	result_t     verdict_q[$];

	function automatic logic [7:0] host_byte(input logic [1:0] k);
		return host_ip[31 - 8*k -: 8];
	endfunction

	function automatic logic [3:0] frame_verdict(input logic [11:0] n);
		if (n < 14) return V_TRUNC;
		if (etype == ETH_IPV4) begin
			if (n < 34) return V_TRUNC;
			if (flg.vhl_bad) return V_BAD_VHL;
			if (csum != 17'h0ffff) return V_BAD_CKSUM;
			if (flg.dst_miss) return V_NOT_OURS;
			if (flg.frag) return V_FRAGMENT;
			if (proto == PROTO_UDP) begin
				if (n < 42) return V_TRUNC;
				if (udp_len != 16'(ip_len - 16'd20)) return V_UDP_LEN;
				return V_UDP;
			end
			if (proto == PROTO_TCP) return (n < 54) ? V_TRUNC : V_TCP;
			return V_UNK_PROTO;
		end
		if (etype == ETH_ARP) begin
			if (n < 42) return V_TRUNC;
			if (flg.arp_fmt) return V_ARP_FMT;
			if (flg.arp_op) return V_ARP_NOT_REQ;
			if (flg.arp_tip) return V_ARP_NOT_OURS;
			return V_ARP_REQ;
		end
		return V_UNK_ETYPE;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic [11:0] p;
		logic [11:0] n;
		logic [16:0] s;
		result_t r;
		p = pos;
		if (p == 0) begin
			etype = 0; csum = 0; proto = 0; ip_len = 0; src_ip = 0;
			sender_mac = 0; ports = 0; seq_ack = 0; udp_len = 0; flg = '0;
		end
		if (p == 12 || p == 13) etype = {etype[7:0], b};
		else if (etype == ETH_IPV4) begin
			if (p >= 14 && p <= 33) begin
				s = csum + ((p & 1) ? {9'd0, b} : {1'b0, b, 8'd0});
				csum = {1'b0, s[15:0]} + s[16];
			end
			if (p == 14 && b != VHL_EXPECTED) flg.vhl_bad = 1;
			if (p == 16 || p == 17) ip_len = {ip_len[7:0], b};
			if ((p == 20 || p == 21) && b != 0) flg.frag = 1;
			if (p == 23) proto = b;
			if (p >= 26 && p <= 29) src_ip = {src_ip[23:0], b};
			if (p >= 30 && p <= 33 && b != host_byte(2'(p - 30))) flg.dst_miss = 1;
			if (p >= 34 && p <= 37) ports = {ports[23:0], b};
			if (p == 38 || p == 39) udp_len = {udp_len[7:0], b};
			if (p >= 38 && p <= 45) seq_ack = {seq_ack[55:0], b};
			if (p == 47) begin
				if (b[1]) flg.syn = 1;
				if (b[4]) flg.ack = 1;
			end
		end else if (etype == ETH_ARP) begin
			if (p >= 14 && p <= 19 && b != arp_fmt_byte(3'(p - 14))) flg.arp_fmt = 1;
			if ((p == 20 && b != 0) || (p == 21 && b != 1)) flg.arp_op = 1;
			if (p >= 22 && p <= 27) sender_mac = {sender_mac[39:0], b};
			if (p >= 28 && p <= 31) src_ip = {src_ip[23:0], b};
			if (p >= 38 && p <= 41 && b != host_byte(2'(p - 38))) flg.arp_tip = 1;
		end
		n = (p + 12'd1 > POS_MAX) ? POS_MAX : p + 12'd1;
		pos = n;
		if (last) begin
			r = '0;
			r.verdict = frame_verdict(n);
			if (r.verdict == V_UDP || r.verdict == V_TCP) begin
				r.remote_ip = src_ip;
				r.local_port = ports[15:0];
				r.remote_port = ports[31:16];
				r.ip_payload_length = ip_len - 16'd20;
				if (r.verdict == V_TCP) begin
					r.syn_ack_seen = flg.syn && flg.ack;
					r.seq_number = seq_ack[63:32];
					r.ack_number = seq_ack[31:0];
				end
			end else if (r.verdict == V_ARP_REQ) begin
				r.remote_ip = src_ip;
				r.remote_mac = sender_mac;
			end
			verdict_q.push_back(r);
			pos = 0;
		end
	endtask

	task automatic check_verdict();
		result_t e;
		result_t a;
		a = {out_ch.verdict, out_ch.remote_ip, out_ch.remote_mac, out_ch.local_port,
			out_ch.remote_port, out_ch.syn_ack_seen, out_ch.seq_number,
			out_ch.ack_number, out_ch.ip_payload_length};
		if (verdict_q.size() == 0) begin
			$display("%0t: unexpected verdict %p", $time, a);
			fail_count++;
			return;
		end
		e = verdict_q.pop_front();
		if (a.verdict !== e.verdict || a.remote_ip !== e.remote_ip
				|| a.remote_mac !== e.remote_mac || a.local_port !== e.local_port
				|| a.remote_port !== e.remote_port || a.syn_ack_seen !== e.syn_ack_seen
				|| a.seq_number !== e.seq_number || a.ack_number !== e.ack_number
				|| a.ip_payload_length !== e.ip_payload_length) begin
			$display("%0t: mismatch expected %p actual %p", $time, e, a);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		verdicts_pending = 0;
		host_ip = LOCAL_IP_RESET;
		pos = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) check_verdict();
			if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.last_byte);
			if (psel && penable && pwrite && pready && paddr == REG_LOCAL_IP)
				host_ip = pwdata;
			verdicts_pending = verdict_q.size();
		end
	end

endmodule

### dv/eth_ip_arp_rx_classifier_unit_test.sv
`timescale 1ns / 100ps
module eth_ip_arp_rx_classifier_unit_test;
	import eiac_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          verdicts_pending;
	int          cycle_count = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          hold_off = 0;
	logic [31:0] host_ip = LOCAL_IP_RESET;
	logic [7:0]  frame_buf[$];

	eiac_in_if  in_ch();
	eiac_out_if out_ch();

	eth_ip_arp_rx_classifier_unit dut (.clk(clk), .arst_n(arst_n), .psel(psel),
		.penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready), .in_ch(in_ch), .out_ch(out_ch));

	eth_ip_arp_rx_classifier_unit_checker checker_i (.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .verdicts_pending(verdicts_pending));

	always #10 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.data_byte = 0;
		in_ch.last_byte = 0;
		out_ch.ready = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1500000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_ch.ready <= 0;
			hold_off <= hold_off - 1;
		end else
			out_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk);
		while (verdicts_pending != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_host_ip(input logic [31:0] v);
		psel <= 1; pwrite <= 1; paddr <= REG_LOCAL_IP; pwdata <= v; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		host_ip = v;
	endtask

	// builds a frame; kind: 0 udp, 1 tcp, 2 arp, 3 other ethertype
	task automatic build_frame(input int kind, input int fault);
		logic [7:0] h[];
		logic [16:0] s;
		logic [15:0] ck;
		int i, n;
		frame_buf.delete();
		n = (kind == 1) ? 54 : 42;
		n = n + ($urandom_range(3) == 0 ? $urandom_range(20) : 0);
		h = new[n];
		for (i = 0; i < n; i++) h[i] = 8'($urandom);
		if (kind == 3) begin
			h[12] = 8'($urandom); h[13] = 8'($urandom);
		end else if (kind == 2) begin
			h[12] = 8'h08; h[13] = 8'h06;
			for (i = 0; i < 6; i++) h[14 + i] = arp_fmt_byte(3'(i));
			h[20] = 0; h[21] = 1;
			for (i = 0; i < 4; i++) h[38 + i] = host_ip[31 - 8*i -: 8];
		end else begin
			h[12] = 8'h08; h[13] = 8'h00;
			h[14] = VHL_EXPECTED;
			h[16] = 0; h[17] = (kind == 1) ? 8'd40 : 8'(8 + $urandom_range(30));
			h[20] = 0; h[21] = 0;
			h[23] = (kind == 1) ? PROTO_TCP : PROTO_UDP;
			for (i = 0; i < 4; i++) h[30 + i] = host_ip[31 - 8*i -: 8];
			h[38] = 0; h[39] = h[17] - 8'd20;
			if ($urandom_range(1)) h[47] = h[47] | 8'h12;
		end
		if (fault == 1) h[$urandom_range(14, 41)] = 8'($urandom);
		if (kind <= 1) begin
			h[24] = 0; h[25] = 0;
			s = 0;
			for (i = 0; i < 10; i++) begin
				s = s + {h[14 + 2*i], h[15 + 2*i]};
				s = s[15:0] + s[16];
			end
			ck = ~s[15:0];
			h[24] = ck[15:8]; h[25] = ck[7:0];
		end
		if (fault == 2) n = $urandom_range(1, n);
		if (fault == 3) h[$urandom_range(14, 33)] ^= 8'(1 << $urandom_range(7));
		for (i = 0; i < n; i++) frame_buf.push_back(h[i]);
	endtask

	task automatic random_phase(input int frames, input int si, input int rs);
		int k;
		send_idle = si;
		recv_stall = rs;
		for (k = 0; k < frames; k++) begin
			if ($urandom_range(9) == 0) begin
				frame_buf.delete();
				repeat ($urandom_range(1, 70)) frame_buf.push_back(8'($urandom));
			end else
				build_frame($urandom_range(3) == 3 ? $urandom_range(3) : $urandom_range(2),
					$urandom_range(5) < 3 ? 0 : $urandom_range(1, 3));
			send_frame();
		end
	endtask

	initial begin
		int k;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_idle = 0;
		recv_stall = 0;
		frame_buf = '{8'hff};
		send_frame();
		for (k = 0; k < 3; k++) begin
			build_frame(k, 0);
			send_frame();
		end
		build_frame(3, 0); send_frame();
		build_frame(0, 2); send_frame();
		build_frame(1, 1); send_frame();
		build_frame(2, 1); send_frame();
		build_frame(0, 3); send_frame();
		drain();
		write_host_ip(32'hffffffff);
		for (k = 0; k < 3; k++) begin
			build_frame(k, 0);
			send_frame();
		end
		drain();
		write_host_ip(32'h00000000);
		random_phase(3, 0, 0);
		hold_off = 300;
		random_phase(3, 0, 0);
		drain();
		write_host_ip($urandom);
		random_phase(2, 78, 0);
		random_phase(2, 0, 78);
		drain();
		write_host_ip(LOCAL_IP_RESET);
		random_phase(2, 9, 9);
		random_phase(2, 0, 0);
		drain();
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
sv/eiac_pkg.sv
sv/eiac_ifs.sv
sv/eiac_parse.sv
sv/eth_ip_arp_rx_classifier_unit.sv
sv/eiac_checker.sv
dv/eth_ip_arp_rx_classifier_unit_checker.sv
dv/eth_ip_arp_rx_classifier_unit_test.sv
